>>> rtl/hs1_pkg.sv
// Package for the HMAC-SHA1 engine: controller states, SHA-1 constants and helpers.
// Used by the controller, datapath and top level.
package hs1_pkg;

  localparam int KeyWords = 8;
  localparam int KeyWordWidth = 64;
  localparam int CfgIndexWidth = 3;

  localparam logic [31:0] Ipad4 = 32'h36363636;
  localparam logic [31:0] Opad4 = 32'h5c5c5c5c;
  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] OuterLen = 32'd672;
  localparam logic [63:0] KeyBits = 64'd512;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hefcdab89;
  localparam logic [31:0] Iv2 = 32'h98badcfe;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hc3d2e1f0;

  // Block sources loaded into the schedule.
  typedef enum logic [2:0] {
    SRC_IPAD,
    SRC_OPAD,
    SRC_MSG,
    SRC_PAD,
    SRC_LEN,
    SRC_OUTER
  } blk_src_t;

  // Where the compression result goes.
  typedef enum logic [1:0] {
    DST_CHAIN,
    DST_INNER,
    DST_OUTER
  } dst_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KEYI,
    ST_ABSORB,
    ST_MSGC,
    ST_PADC,
    ST_LENC,
    ST_KEYO,
    ST_OUTC,
    ST_EMIT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic     take;       // fold an accepted byte into the block buffer
    logic     start;      // begin a compression
    blk_src_t src;
    logic     from_iv;    // chaining input is the IV instead of the chain, inner or outer register
    dst_t     dst;
    logic     clear_msg;  // back to the message reset values
    logic     emit_next;  // one digest word transferred
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       busy;
    logic       block_full;
    logic       pad_spill;   // fill of 56 or more: the length needs its own block
    logic [2:0] emit_idx;
  } dp_stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

endpackage

>>> rtl/hs1_stream_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface hs1_stream_if #(parameter int Width = 8);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/hmac_sha1_engine.sv
// HMAC-SHA1 engine top level: key registers, controller and datapath.
// Depends on hs1_pkg, hs1_stream_if, hs1_ctrl and hs1_datapath.
//
// The engine hashes at most one message byte per input transfer and returns
// the five-word HMAC-SHA1 digest after a transfer with end_of_msg set. The user
// must write the key as eight 64-bit words through the configuration port only
// while the engine is idle; the block itself does not enforce this. One shared
// SHA-1 round unit runs every compression. A byte that fills a block adds one
// compression. The first transfer of a message first hashes the inner key
// block. The final transfer adds one or two inner padding compressions and two
// outer ones before the five digest words are offered, one per output transfer.
module hmac_sha1_engine import hs1_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  hs1_stream_if.sink               msg_in,
  hs1_stream_if.source             digest_out,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [KeyWordWidth-1:0]  cfg_data
);

  // Input payload: {msg_byte, has_byte, end_of_msg}.
  // Output payload: {digest_word, word_index, last_word}.
  logic [KeyWordWidth-1:0] key [KeyWords];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyWords; i++) key[i] <= '0;
    end else if (cfg_we) begin
      key[cfg_index] <= cfg_data;
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  hs1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg_in.valid),
    .in_has   (msg_in.data[1]),
    .in_last  (msg_in.data[0]),
    .in_ready (msg_in.ready),
    .out_valid(digest_out.valid),
    .out_ready(digest_out.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hs1_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .msg_byte   (msg_in.data[9:2]),
    .cmd        (cmd),
    .stat       (stat),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

  assign digest_out.data = {digest_word, word_index, last_word};

endmodule

>>> rtl/hs1_ctrl.sv
// Controller state machine for the HMAC-SHA1 engine.
// Depends on hs1_pkg.
module hs1_ctrl import hs1_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_has,
  input  logic     in_last,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state, state_next;
  logic   started, started_next;
  logic   pending_last, pending_last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      started <= 1'b0;
      pending_last <= 1'b0;
    end else begin
      state <= state_next;
      started <= started_next;
      pending_last <= pending_last_next;
    end
  end

  logic acc;
  assign acc = in_valid && in_ready;

  always_comb begin
    state_next = state;
    started_next = started;
    pending_last_next = pending_last;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (!started) begin
            state_next = ST_KEYI;
          end else begin
            state_next = ST_ABSORB;
          end
        end
      end
      ST_KEYI: begin
        if (!stat.busy) begin
          started_next = 1'b1;
          state_next = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        pending_last_next = in_last;
        if (in_has && stat.block_full) begin
          state_next = ST_MSGC;
        end else if (in_last) begin
          state_next = ST_PADC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MSGC: begin
        if (!stat.busy) begin
          state_next = pending_last ? ST_PADC : ST_IDLE;
        end
      end
      ST_PADC: begin
        if (!stat.busy) begin
          state_next = stat.pad_spill ? ST_LENC : ST_KEYO;
        end
      end
      ST_LENC: begin
        if (!stat.busy) begin
          state_next = ST_KEYO;
        end
      end
      ST_KEYO: begin
        if (!stat.busy) begin
          state_next = ST_OUTC;
        end
      end
      ST_OUTC: begin
        if (!stat.busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready && stat.emit_idx == 3'd4) begin
          started_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A compression is started on the first cycle of each compute state; busy
  // rises on the next edge, so start is gated with a one-shot flag.
  logic launched, launched_next;
  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
    end else begin
      launched <= launched_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.src = SRC_MSG;
    cmd.dst = DST_CHAIN;
    in_ready = 1'b0;
    out_valid = 1'b0;
    launched_next = 1'b0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_KEYI: begin
        cmd.src = SRC_IPAD;
        cmd.from_iv = 1'b1;
        cmd.dst = DST_CHAIN;
        cmd.start = !launched;
        launched_next = stat.busy || !launched;
        if (launched && !stat.busy) launched_next = 1'b0;
      end
      ST_ABSORB: begin
        in_ready = 1'b1;
        cmd.take = acc && in_has;
      end
      ST_MSGC, ST_PADC, ST_LENC, ST_KEYO, ST_OUTC: begin
        unique case (state)
          ST_MSGC: begin cmd.src = SRC_MSG; cmd.dst = DST_CHAIN; end
          ST_PADC: begin
            cmd.src = SRC_PAD;
            cmd.dst = DST_INNER;
          end
          ST_LENC: begin cmd.src = SRC_LEN; cmd.dst = DST_INNER; end
          ST_KEYO: begin cmd.src = SRC_OPAD; cmd.dst = DST_OUTER; cmd.from_iv = 1'b1; end
          default: begin cmd.src = SRC_OUTER; cmd.dst = DST_OUTER; end
        endcase
        cmd.start = !launched;
        launched_next = !(launched && !stat.busy);
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit_next = out_ready;
        cmd.clear_msg = out_ready && stat.emit_idx == 3'd4;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/hs1_datapath.sv
// Datapath for the HMAC-SHA1 engine: block buffer, counters, round unit and digests.
// Depends on hs1_pkg.
module hs1_datapath import hs1_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [KeyWordWidth-1:0] key [KeyWords],
  input  logic [7:0]              msg_byte,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  output logic [31:0]             digest_word,
  output logic [2:0]              word_index,
  output logic                    last_word
);

  logic [31:0] blk [16];
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [31:0] chain [5];
  logic [31:0] inner [5];
  logic [31:0] outer [5];
  logic [2:0]  emit_idx;

  // Round unit state.
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h_in [5];
  logic [6:0]  rnd;
  logic        busy;
  dst_t        dst;

  // Block source words.
  logic [31:0] src_word [16];
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      logic [31:0] kw;
      kw = i[0] ? key[i/2][31:0] : key[i/2][63:32];
      unique case (cmd.src)
        SRC_IPAD: src_word[i] = kw ^ Ipad4;
        SRC_OPAD: src_word[i] = kw ^ Opad4;
        SRC_MSG: src_word[i] = blk[i];
        SRC_PAD: begin
          src_word[i] = blk[i];
          if (i == 32'(fill[5:2])) begin
            src_word[i] = blk[i] | (PadWord >> {fill[1:0], 3'b000});
          end
          if (!fill[5] || fill[5:3] != 3'b111) begin
            if (i == 14) src_word[i] = bit_len[63:32];
            if (i == 15) src_word[i] = bit_len[31:0];
          end
        end
        SRC_LEN: begin
          src_word[i] = '0;
          if (i == 14) src_word[i] = bit_len[63:32];
          if (i == 15) src_word[i] = bit_len[31:0];
        end
        SRC_OUTER: begin
          src_word[i] = '0;
          if (i < 5) src_word[i] = inner[i % 5];
          if (i == 5) src_word[i] = PadWord;
          if (i == 15) src_word[i] = OuterLen;
        end
        default: src_word[i] = '0;
      endcase
    end
  end

  // One SHA-1 round.
  logic [6:0]  t;
  logic [31:0] wt, wnew, f, k, tmp;
  always_comb begin
    t = rnd;
    wnew = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 5'd1);
    wt = (t < 7'd16) ? w[0] : wnew;
    if (t < 7'd20) begin
      f = (b & c) | (~b & d); k = 32'h5a827999;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d; k = 32'h6ed9eba1;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
    end else begin
      f = b ^ c ^ d; k = 32'hca62c1d6;
    end
    tmp = rotl(a, 5'd5) + f + e + wt + k;
  end

  // The schedule is a shift line: w[0] is the current word for t below 16, then wnew.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd <= '0;
    end else if (cmd.start && !busy) begin
      busy <= 1'b1;
      rnd <= '0;
    end else if (busy) begin
      rnd <= rnd + 7'd1;
      if (rnd == 7'd80) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      for (int i = 0; i < 16; i++) w[i] <= src_word[i];
      if (cmd.from_iv) begin
        h_in[0] <= Iv0; h_in[1] <= Iv1; h_in[2] <= Iv2; h_in[3] <= Iv3; h_in[4] <= Iv4;
        a <= Iv0; b <= Iv1; c <= Iv2; d <= Iv3; e <= Iv4;
      end else if (cmd.src == SRC_OUTER) begin
        for (int i = 0; i < 5; i++) h_in[i] <= outer[i];
        a <= outer[0]; b <= outer[1]; c <= outer[2]; d <= outer[3]; e <= outer[4];
      end else if (cmd.src == SRC_LEN) begin
        for (int i = 0; i < 5; i++) h_in[i] <= inner[i];
        a <= inner[0]; b <= inner[1]; c <= inner[2]; d <= inner[3]; e <= inner[4];
      end else begin
        for (int i = 0; i < 5; i++) h_in[i] <= chain[i];
        a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3]; e <= chain[4];
      end
      dst <= cmd.dst;
    end else if (busy && rnd < 7'd80) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      e <= d; d <= c; c <= rotl(b, 5'd30); b <= a; a <= tmp;
    end
  end

  // Feed-forward on the last busy cycle.
  logic [31:0] sum [5];
  always_comb begin
    sum[0] = h_in[0] + a; sum[1] = h_in[1] + b; sum[2] = h_in[2] + c;
    sum[3] = h_in[3] + d; sum[4] = h_in[4] + e;
  end

  logic done;
  assign done = busy && rnd == 7'd80;

  always_ff @(posedge clk) begin
    if (done) begin
      unique case (dst)
        DST_CHAIN: for (int i = 0; i < 5; i++) chain[i] <= sum[i];
        DST_INNER: for (int i = 0; i < 5; i++) inner[i] <= sum[i];
        default: for (int i = 0; i < 5; i++) outer[i] <= sum[i];
      endcase
    end
  end

  // Block buffer, fill and length.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_msg) begin
      for (int i = 0; i < 16; i++) blk[i] <= '0;
      fill <= '0;
      bit_len <= KeyBits;
    end else if (cmd.take) begin
      blk[fill[5:2]] <= blk[fill[5:2]] | ({24'd0, msg_byte} << (5'd24 - {fill[1:0], 3'b000}));
      fill <= fill + 6'd1;
      bit_len <= bit_len + 64'd8;
    end else if (done && dst == DST_CHAIN && fill == '0) begin
      for (int i = 0; i < 16; i++) blk[i] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_msg) begin
      emit_idx <= '0;
    end else if (cmd.emit_next) begin
      emit_idx <= emit_idx + 3'd1;
    end
  end

  assign stat.busy = busy || cmd.start;
  assign stat.block_full = (fill == 6'd63);
  assign stat.pad_spill = (fill >= 6'd56);
  assign stat.emit_idx = emit_idx;
  assign digest_word = outer[emit_idx];
  assign word_index = emit_idx;
  assign last_word = (emit_idx == 3'd4);

endmodule

>>> rtl/hs1_checker.sv
// Port-level checker for the HMAC-SHA1 engine, bound to the top level.
// Depends on nothing beyond the top level's ports.
module hs1_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [35:0] out_data
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while digest pending");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data[3:1] <= 3'd4) else $error("word index out of range");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data[0] == (out_data[3:1] == 3'd4))) else $error("last flag wrong");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("stall lost data");

endmodule

bind hmac_sha1_engine hs1_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .in_valid (msg_in.valid),
  .in_ready (msg_in.ready),
  .out_valid(digest_out.valid),
  .out_ready(digest_out.ready),
  .out_data (digest_out.data)
);
